// File: design/adm_pkg.sv
// Shared constants and types for the accelerometer deviation magnitude block.
package adm_pkg;

    localparam int ACCEL_W         = 12;   // width of one axis field on the input
    localparam int IN_DATA_W       = 40;   // three axis fields, padded to bytes
    localparam int DEV_W           = 17;   // deviation field width
    localparam int OUT_DATA_W      = 24;   // deviation padded to bytes
    localparam int HIST_W          = 10;   // history counter / min_history width

    localparam int WINDOW_DEF      = 100;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [HIST_W-1:0] HIST_MAX    = 10'd1023;
    localparam logic [HIST_W-1:0] MINH_RESET  = 10'd103;
    localparam logic [DEV_W-1:0]  DEV_MAX     = 17'd131071;

    // Ring commands from the sequencer.
    typedef struct packed {
        logic rd;   // read the oldest entry
        logic wr;   // replace it with the new sample, update sums
    } ring_ctl_t;

endpackage

// File: design/adm_ring.sv
// Sample ring memory with per-entry valid bits, running axis sums and history count.
module adm_ring #(
    parameter int WINDOW      = adm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = adm_pkg::SAMPLE_BITS_DEF,
    localparam int SB   = (SAMPLE_BITS < adm_pkg::ACCEL_W) ? SAMPLE_BITS : adm_pkg::ACCEL_W,
    localparam int SUMW = SB + $clog2(WINDOW + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  adm_pkg::ring_ctl_t         ctl,
    input  logic [3*SB-1:0]            sample,
    output logic [3*SUMW-1:0]          sums,
    output logic [adm_pkg::HIST_W-1:0] hist
);
    import adm_pkg::*;

    localparam int PW = $clog2(WINDOW);

    logic [3*SB-1:0]   mem [WINDOW];
    logic [3*SB-1:0]   rdat_reg;
    logic              old_vld_reg;
    logic [WINDOW-1:0] vld_reg;
    logic [PW-1:0]     ptr_reg;
    logic [PW-1:0]     ptr_next;
    logic [HIST_W-1:0] hist_reg;
    logic [SUMW-1:0]   sum_reg  [3];
    logic [SUMW-1:0]   sum_next [3];
    logic [3*SB-1:0]   old_smp;

    assign ptr_next = (ptr_reg == PW'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    // never-written entries count as zero samples
    assign old_smp  = old_vld_reg ? rdat_reg : '0;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum_next[a] = sum_reg[a] - SUMW'(old_smp[a*SB +: SB]) + SUMW'(sample[a*SB +: SB]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            mem[ptr_reg] <= sample;
        end
        if (ctl.rd) begin
            rdat_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            old_vld_reg <= 1'b0;
            ptr_reg     <= '0;
            hist_reg    <= '0;
            for (int a = 0; a < 3; a++) begin
                sum_reg[a] <= '0;
            end
        end else begin
            if (ctl.rd) begin
                old_vld_reg <= vld_reg[ptr_reg];
            end
            if (ctl.wr) begin
                vld_reg[ptr_reg] <= 1'b1;
                ptr_reg          <= ptr_next;
                if (hist_reg != HIST_MAX) begin
                    hist_reg <= hist_reg + 1'b1;
                end
                for (int a = 0; a < 3; a++) begin
                    sum_reg[a] <= sum_next[a];
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sums[a*SUMW +: SUMW] = sum_reg[a];
        end
    end

    assign hist = hist_reg;

endmodule

// File: design/adm_mul.sv
// Shared unsigned multiplier with registered product.
module adm_mul #(
    parameter int OPW = 26
) (
    input  logic             aclk,
    input  logic [OPW-1:0]   op_a,
    input  logic [OPW-1:0]   op_b,
    output logic [2*OPW-1:0] prod
);
    logic [2*OPW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// File: design/adm_calc.sv
// Sequencer: squared deviation, bit-serial square root, divide by window, output register.
module adm_calc #(
    parameter int WINDOW      = adm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = adm_pkg::SAMPLE_BITS_DEF,
    localparam int SB   = (SAMPLE_BITS < adm_pkg::ACCEL_W) ? SAMPLE_BITS : adm_pkg::ACCEL_W,
    localparam int SUMW = SB + $clog2(WINDOW + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_take,
    input  logic [3*SB-1:0]            sample,
    input  logic [adm_pkg::HIST_W-1:0] min_hist,
    input  logic [3*SUMW-1:0]          sums,
    input  logic [adm_pkg::HIST_W-1:0] hist,
    output adm_pkg::ring_ctl_t         ring_ctl,
    output logic [3*SB-1:0]            held_sample,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [adm_pkg::DEV_W-1:0]  out_dev,
    output logic                       out_rdy
);
    import adm_pkg::*;

    localparam int SQW = 2 * SUMW + 2;          // sum of three squares
    localparam int VW  = SQW + 8;               // radicand, times 256
    localparam int RW  = (VW + 1) / 2;          // root width
    localparam int VW2 = 2 * RW;
    localparam int CW  = $clog2(RW + 1);
    localparam int QW  = (RW > DEV_W) ? RW : DEV_W;
    localparam logic [RW-1:0]   RCP   = RW'((64'd1 << RW) / WINDOW);
    localparam logic [RW-1:0]   WIN   = RW'(WINDOW);
    localparam logic [SUMW-1:0] WIN_S = SUMW'(WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAG, ST_SQ, ST_ROOT, ST_RCP, ST_QW, ST_FIX, ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic            ovld_reg, ovld_next;
    logic [CW-1:0]   cnt_reg;
    logic [3*SB-1:0] smp_reg;
    logic            rdy_reg;
    logic [SUMW-1:0] mag_reg [3];
    logic [SUMW-1:0] mag_new [3];
    logic [SQW-1:0]  acc_reg;
    logic [SQW-1:0]  acc_sum;
    logic [VW2-1:0]  v_reg;
    logic [RW:0]     rem_reg;
    logic [RW-1:0]   root_reg;
    logic [RW-1:0]   q_reg;
    logic [DEV_W-1:0] odev_reg;
    logic            ordy_reg;

    logic [RW-1:0]   mul_a, mul_b;
    logic [2*RW-1:0] prod;
    logic [SUMW-1:0] mag_sel;
    logic [RW+1:0]   rem_sh, trial;
    logic            ge;
    logic [RW-1:0]   fix_diff;
    logic [QW-1:0]   q_ext;
    logic [DEV_W-1:0] dev_sat;
    logic            out_free;

    adm_mul #(.OPW(RW)) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // |W*s - sum| per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic [SUMW-1:0] scl;
            logic [SUMW-1:0] sm;
            scl = WIN_S * SUMW'(smp_reg[a*SB +: SB]);
            sm  = sums[a*SUMW +: SUMW];
            mag_new[a] = (scl >= sm) ? scl - sm : sm - scl;
        end
    end

    always_comb begin
        case (cnt_reg[1:0])
            2'd1:    mag_sel = mag_reg[1];
            2'd2:    mag_sel = mag_reg[2];
            default: mag_sel = mag_reg[0];
        endcase
    end

    always_comb begin
        unique case (state_reg)
            ST_SQ: begin
                mul_a = RW'(mag_sel);
                mul_b = RW'(mag_sel);
            end
            ST_RCP: begin
                mul_a = root_reg;
                mul_b = RCP;
            end
            ST_QW: begin
                mul_a = prod[2*RW-1:RW];
                mul_b = WIN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_sum  = acc_reg + prod[SQW-1:0];

    // one root bit per step
    assign rem_sh   = {rem_reg[RW-1:0], v_reg[VW2-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign ge       = rem_sh >= trial;

    // quotient estimate is low by at most one
    assign fix_diff = root_reg - prod[RW-1:0];

    assign q_ext    = QW'(q_reg);
    assign dev_sat  = (q_ext > QW'(DEV_MAX)) ? DEV_MAX : q_ext[DEV_W-1:0];
    assign out_free = !ovld_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        ovld_next  = ovld_reg;
        if (ovld_reg && out_ready) begin
            ovld_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_MAG;
            ST_MAG:  state_next = rdy_reg ? ST_SQ : ST_DONE;
            ST_SQ:   if (cnt_reg[1:0] == 2'd3) state_next = ST_ROOT;
            ST_ROOT: if (cnt_reg == CW'(RW - 1)) state_next = ST_RCP;
            ST_RCP:  state_next = ST_QW;
            ST_QW:   state_next = ST_FIX;
            ST_FIX:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    ovld_next  = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ovld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
            if (state_reg == ST_DONE && out_free) begin
                odev_reg <= dev_sat;
                ordy_reg <= rdy_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    smp_reg <= sample;
                    rdy_reg <= hist >= min_hist;
                end
            end
            ST_MAG: begin
                for (int a = 0; a < 3; a++) begin
                    mag_reg[a] <= mag_new[a];
                end
                acc_reg <= '0;
                cnt_reg <= '0;
                q_reg   <= '0;
            end
            ST_SQ: begin
                if (cnt_reg[1:0] != 2'd0) begin
                    acc_reg <= acc_sum;
                end
                if (cnt_reg[1:0] == 2'd3) begin
                    v_reg    <= VW2'({acc_sum, 8'h00});
                    rem_reg  <= '0;
                    root_reg <= '0;
                    cnt_reg  <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ST_ROOT: begin
                v_reg    <= v_reg << 2;
                rem_reg  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
                root_reg <= {root_reg[RW-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            ST_QW: begin
                q_reg <= prod[2*RW-1:RW];
            end
            ST_FIX: begin
                q_reg <= q_reg + RW'(fix_diff >= WIN);
            end
            default: ;
        endcase
    end

    assign ring_ctl.rd = in_take;
    assign ring_ctl.wr = (state_reg == ST_MAG);
    assign held_sample = smp_reg;
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = ovld_reg;
    assign out_dev     = odev_reg;
    assign out_rdy     = ordy_reg;

endmodule

// File: design/accel_deviation_magnitude.sv
// Top level: accelerometer deviation-from-window-mean magnitude with stream ports.
//
// Usage:
//  - s_ channel carries one three-axis sample per transfer; only the low
//    SAMPLE_BITS bits of each axis are used.
//  - m_ channel returns one result per sample: deviation = floor(16*|v|) where
//    v is the sample minus the mean of the previous WINDOW samples, saturated
//    at 131071; tuser is 1 when at least min_history samples preceded it.
//    Otherwise deviation is 0 and tuser is 0.
//  - cfg_ channel writes min_history (reset value 103); write only while idle.
// Timing:
//  - A ready sample steps through MAG, SQ, ROOT, RCP, QW, FIX and DONE before
//    its result is registered, and the next transfer is taken back in IDLE;
//    the root is RW = ceil((2*SUMW+10)/2) bits wide, SUMW = SB + clog2(WINDOW+1).
//    The bit-serial square root (one bit per cycle) dominates.
//  - A not-ready sample goes from MAG straight to DONE, then back to IDLE.
//  - The result sits in an output register; the next sample is taken while it
//    waits. If the receiver still holds off when the next result is done, the
//    sequencer waits until the register frees. s_tready is high only between items.
// Reset: unwritten ring entries read as zero; sums, pointer, history clear; min_history 103.
module accel_deviation_magnitude #(
    parameter int WINDOW      = adm_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = adm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // sample stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [adm_pkg::IN_DATA_W-1:0]  s_tdata,   // accel_x[11:0], accel_y[23:12],
                                                      // accel_z[35:24], zero pad
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [adm_pkg::OUT_DATA_W-1:0] m_tdata,   // deviation[16:0], zero pad
    output logic [0:0]                     m_tuser,   // ready_res
    // register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [adm_pkg::HIST_W-1:0]     cfg_data   // min_history
);
    import adm_pkg::*;

    localparam int SB   = (SAMPLE_BITS < ACCEL_W) ? SAMPLE_BITS : ACCEL_W;
    localparam int SUMW = SB + $clog2(WINDOW + 1);

    logic [HIST_W-1:0] min_hist_reg;
    logic [3*SB-1:0]   sample;
    logic [3*SB-1:0]   smp_held;
    logic              in_take;
    ring_ctl_t         ring_ctl;
    logic [3*SUMW-1:0] sums;
    logic [HIST_W-1:0] hist;
    logic [DEV_W-1:0]  dev;
    logic              rdy;

    // min_history register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_hist_reg <= MINH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            min_hist_reg <= cfg_data;
        end
    end

    // keep only the used sample bits of each axis
    assign sample  = {s_tdata[2*ACCEL_W +: SB], s_tdata[ACCEL_W +: SB], s_tdata[0 +: SB]};
    assign in_take = s_tvalid && s_tready;

    // ring update uses the sample held since its transfer
    adm_ring #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ring_ctl),
        .sample  (smp_held),
        .sums    (sums),
        .hist    (hist)
    );

    adm_calc #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_calc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_take     (in_take),
        .sample      (sample),
        .min_hist    (min_hist_reg),
        .sums        (sums),
        .hist        (hist),
        .ring_ctl    (ring_ctl),
        .held_sample (smp_held),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_dev     (dev),
        .out_rdy     (rdy)
    );

    assign m_tdata = {(OUT_DATA_W - DEV_W)'(0), dev};
    assign m_tuser = rdy;

    // a result without enough history carries zero deviation
    a_not_ready_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[DEV_W-1:0] == '0)
        else $error("not-ready result with nonzero deviation");

    // one item at a time: input closes right after a transfer
    a_busy_after_take : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // a new result only comes out of a busy sequencer
    a_result_from_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in progress");

endmodule
